// ===== src/cbp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbp_pkg - shared types and constants of the credential blob parser
// Request payload types, status and opcode codes, and blob layout constants.
// ----------------------------------------------------------------------------
package cbp_pkg;

  // Blob layout and store sizes
  localparam int BLOB_LIMIT = 1024;
  localparam int BLOB_MIN   = 4;
  localparam int NAME_BYTES = 32;
  localparam int PASS_BYTES = 64;
  localparam int ADDR_LEN   = 6;
  localparam int STATIC_LEN = 20;
  localparam int HDR_LAST   = 2;

  // State widths
  localparam int BC_W = 11;
  localparam int EL_W = 8;
  localparam int NC_W = 6;
  localparam int PC_W = 7;
  localparam int SK_W = 5;
  localparam int NA_W = 5;   // name store address
  localparam int PA_W = 6;   // passphrase store address
  localparam int CFG_W = 7;

  // Opcodes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Read selection
  localparam logic SEL_NAME = 1'b0;
  localparam logic SEL_PASS = 1'b1;

  // Configuration register indexes
  localparam logic CFG_NAME_ROOM = 1'b0;
  localparam logic CFG_PASS_ROOM = 1'b1;

  // Status codes
  localparam logic [1:0] ST_FOUND   = 2'd0;
  localparam logic [1:0] ST_NONE    = 2'd1;
  localparam logic [1:0] ST_BAD_LEN = 2'd2;

  typedef enum logic [6:0] {
    PH_HEADER = 7'b0000001,
    PH_NAME   = 7'b0000010,
    PH_PASS   = 7'b0000100,
    PH_ADDR   = 7'b0001000,
    PH_MODE   = 7'b0010000,
    PH_SKIP   = 7'b0100000,
    PH_DONE   = 7'b1000000
  } phase_e;

  typedef struct packed {
    logic       opcode;
    logic [7:0] blob_byte;
    logic       final_byte;
    logic       read_which;
    logic [5:0] read_index;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] name_length;
    logic [6:0] pass_length;
    logic [7:0] read_data;
  } rsp_t;

endpackage
`default_nettype wire

// ===== src/credential_blob_parser_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// credential_blob_parser_core - streaming credential blob parser
// Parses a credential blob one byte per request, keeps the first acceptable
// entry in name and passphrase stores, reports the outcome on the final byte
// and serves byte reads of the kept credential.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                          | Moves
//  --------+----------------------------------+------------------------------
//  in      | in_valid_i / in_ready_o / in_data_i   | one push or read request
//  out     | out_valid_o / out_ready_i / out_data_o | one status/read response
//  cfg     | cfg_we_i / cfg_idx_i / cfg_data_i     | room register write
//
//  One request per cycle. All parsing for a request is done between the
//  request edge and the response register, so a response appears in the
//  cycle after its request is taken. The response register sets the rate:
//  a new request is taken whenever that register is empty or drained in the
//  same cycle. Reset is asynchronous and clears all parser state at once; the
//  name and passphrase stores are not cleared and are only read below the
//  kept lengths. Non-final pushes produce no response.
//
module credential_blob_parser_core (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_ready_o,
  input  wire cbp_pkg::req_t        in_data_i,
  output logic                      out_valid_o,
  input  wire                       out_ready_i,
  output cbp_pkg::rsp_t             out_data_o,
  input  wire                       cfg_we_i,
  input  wire                       cfg_idx_i,
  input  wire [cbp_pkg::CFG_W-1:0]  cfg_data_i
);

  // Configuration
  logic [cbp_pkg::NC_W-1:0] name_room_q;
  logic [cbp_pkg::PC_W-1:0] pass_room_q;

  // Parser state
  cbp_pkg::phase_e          phase_q, phase_d;
  logic [cbp_pkg::BC_W-1:0] bc_q, bc_d;
  logic [cbp_pkg::EL_W-1:0] el_q, el_d, el_dec;
  logic [cbp_pkg::NC_W-1:0] nc_q, nc_d;
  logic [cbp_pkg::PC_W-1:0] pc_q, pc_d;
  logic [cbp_pkg::SK_W-1:0] sk_q, sk_d, sk_inc;
  logic                     adopted_q, adopted_d;
  logic                     kept_q, kept_d;        // found result available
  logic [cbp_pkg::NC_W-1:0] kn_q, kn_d;
  logic [cbp_pkg::PC_W-1:0] kp_q, kp_d;

  // Response register
  logic                     out_valid_q, out_valid_d;
  logic [1:0]               st_q, st_d;
  logic [cbp_pkg::NC_W-1:0] rn_q, rn_d;
  logic [cbp_pkg::PC_W-1:0] rp_q, rp_d;
  logic                     gate_q, gate_d;
  logic                     sel_q;

  // Stores
  logic [7:0] name_mem [cbp_pkg::NAME_BYTES];
  logic [7:0] pass_mem [cbp_pkg::PASS_BYTES];
  logic [7:0] name_rd_q, pass_rd_q;
  logic       name_we, pass_we;

  logic                     in_fire, push, rd_req, bad_len, adopt_ok;
  logic [cbp_pkg::NC_W-1:0] nroom;
  logic [cbp_pkg::PC_W-1:0] proom;
  logic [7:0]               b;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign push       = in_fire && (in_data_i.opcode == cbp_pkg::OP_PUSH);
  assign rd_req     = in_fire && (in_data_i.opcode == cbp_pkg::OP_READ);
  assign b          = in_data_i.blob_byte;

  // Clamp the rooms to one above the store sizes
  assign nroom = (name_room_q > cbp_pkg::NC_W'(cbp_pkg::NAME_BYTES + 1))
               ? cbp_pkg::NC_W'(cbp_pkg::NAME_BYTES + 1) : name_room_q;
  assign proom = (pass_room_q > cbp_pkg::PC_W'(cbp_pkg::PASS_BYTES + 1))
               ? cbp_pkg::PC_W'(cbp_pkg::PASS_BYTES + 1) : pass_room_q;
  assign adopt_ok = !adopted_q && (nc_q != '0) && (nc_q < nroom) && (pc_q < proom);

  assign el_dec = (el_q != '0) ? el_q - 1'b1 : el_q;
  assign sk_inc = sk_q + 1'b1;

  always_comb begin
    phase_d     = phase_q;
    bc_d        = bc_q;
    el_d        = el_q;
    nc_d        = nc_q;
    pc_d        = pc_q;
    sk_d        = sk_q;
    adopted_d   = adopted_q;
    kept_d      = kept_q;
    kn_d        = kn_q;
    kp_d        = kp_q;
    name_we     = 1'b0;
    pass_we     = 1'b0;
    bad_len     = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    st_d        = st_q;
    rn_d        = rn_q;
    rp_d        = rp_q;
    gate_d      = gate_q;

    if (push) begin
      case (phase_q)
        cbp_pkg::PH_HEADER: begin
          if (bc_q == '0) begin
            // Entry count; a new blob hides the previous credential
            el_d      = b;
            adopted_d = 1'b0;
            kept_d    = 1'b0;
            kn_d      = '0;
            kp_d      = '0;
          end else if (bc_q >= cbp_pkg::BC_W'(cbp_pkg::HDR_LAST)) begin
            nc_d    = '0;
            pc_d    = '0;
            sk_d    = '0;
            phase_d = (el_q != '0) ? cbp_pkg::PH_NAME : cbp_pkg::PH_DONE;
          end
        end
        cbp_pkg::PH_NAME: begin
          if (b == 8'd0) begin
            phase_d = cbp_pkg::PH_PASS;
          end else begin
            name_we = !adopted_q && (nc_q < cbp_pkg::NC_W'(cbp_pkg::NAME_BYTES));
            if (nc_q < cbp_pkg::NC_W'(cbp_pkg::NAME_BYTES + 1)) begin
              nc_d = nc_q + 1'b1;
            end
          end
        end
        cbp_pkg::PH_PASS: begin
          if (b == 8'd0) begin
            phase_d = cbp_pkg::PH_ADDR;
            sk_d    = '0;
          end else begin
            pass_we = !adopted_q && (pc_q < cbp_pkg::PC_W'(cbp_pkg::PASS_BYTES));
            if (pc_q < cbp_pkg::PC_W'(cbp_pkg::PASS_BYTES + 1)) begin
              pc_d = pc_q + 1'b1;
            end
          end
        end
        cbp_pkg::PH_ADDR: begin
          sk_d = sk_inc;
          if (sk_inc >= cbp_pkg::SK_W'(cbp_pkg::ADDR_LEN)) begin
            phase_d = cbp_pkg::PH_MODE;
          end
        end
        cbp_pkg::PH_MODE: begin
          if (adopt_ok) begin
            adopted_d = 1'b1;
            kn_d      = nc_q;
            kp_d      = pc_q;
          end
          el_d = el_dec;
          if (b == 8'd1) begin
            phase_d = cbp_pkg::PH_SKIP;
            sk_d    = '0;
          end else begin
            nc_d    = '0;
            pc_d    = '0;
            sk_d    = '0;
            phase_d = (el_dec != '0) ? cbp_pkg::PH_NAME : cbp_pkg::PH_DONE;
          end
        end
        cbp_pkg::PH_SKIP: begin
          sk_d = sk_inc;
          if (sk_inc >= cbp_pkg::SK_W'(cbp_pkg::STATIC_LEN)) begin
            nc_d    = '0;
            pc_d    = '0;
            sk_d    = '0;
            phase_d = (el_q != '0) ? cbp_pkg::PH_NAME : cbp_pkg::PH_DONE;
          end
        end
        default: begin
        end
      endcase

      // Count blob bytes, saturating one above the limit
      if (bc_q < cbp_pkg::BC_W'(cbp_pkg::BLOB_LIMIT + 1)) begin
        bc_d = bc_q + 1'b1;
      end

      if (in_data_i.final_byte) begin
        bad_len = (bc_d < cbp_pkg::BC_W'(cbp_pkg::BLOB_MIN)) ||
                  (bc_d > cbp_pkg::BC_W'(cbp_pkg::BLOB_LIMIT));
        st_d    = bad_len ? cbp_pkg::ST_BAD_LEN
                : (adopted_d ? cbp_pkg::ST_FOUND : cbp_pkg::ST_NONE);
        kept_d  = !bad_len && adopted_d;
        if (!kept_d) begin
          kn_d = '0;
          kp_d = '0;
        end
        // Rearm for the next blob
        adopted_d   = 1'b0;
        phase_d     = cbp_pkg::PH_HEADER;
        bc_d        = '0;
        el_d        = '0;
        nc_d        = '0;
        pc_d        = '0;
        sk_d        = '0;
        out_valid_d = 1'b1;
        rn_d        = kn_d;
        rp_d        = kp_d;
        gate_d      = 1'b0;
      end
    end else if (rd_req) begin
      out_valid_d = 1'b1;
      st_d        = cbp_pkg::ST_FOUND;
      rn_d        = kept_q ? kn_q : '0;
      rp_d        = kept_q ? kp_q : '0;
      if (in_data_i.read_which == cbp_pkg::SEL_NAME) begin
        gate_d = kept_q && (in_data_i.read_index < kn_q) &&
                 (in_data_i.read_index < cbp_pkg::NC_W'(cbp_pkg::NAME_BYTES));
      end else begin
        gate_d = kept_q && ({1'b0, in_data_i.read_index} < kp_q);
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_room_q <= cbp_pkg::NC_W'(cbp_pkg::NAME_BYTES + 1);
      pass_room_q <= cbp_pkg::PC_W'(cbp_pkg::PASS_BYTES + 1);
      phase_q     <= cbp_pkg::PH_HEADER;
      bc_q        <= '0;
      el_q        <= '0;
      nc_q        <= '0;
      pc_q        <= '0;
      sk_q        <= '0;
      adopted_q   <= 1'b0;
      kept_q      <= 1'b0;
      kn_q        <= '0;
      kp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == cbp_pkg::CFG_NAME_ROOM) begin
          name_room_q <= cfg_data_i[cbp_pkg::NC_W-1:0];
        end else begin
          pass_room_q <= cfg_data_i;
        end
      end
      phase_q     <= phase_d;
      bc_q        <= bc_d;
      el_q        <= el_d;
      nc_q        <= nc_d;
      pc_q        <= pc_d;
      sk_q        <= sk_d;
      adopted_q   <= adopted_d;
      kept_q      <= kept_d;
      kn_q        <= kn_d;
      kp_q        <= kp_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Response payload: load only when a request is taken
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      st_q   <= st_d;
      rn_q   <= rn_d;
      rp_q   <= rp_d;
      gate_q <= gate_d;
      sel_q  <= in_data_i.read_which;
    end
  end

  // Name store: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (name_we) begin
      name_mem[nc_q[cbp_pkg::NA_W-1:0]] <= b;
    end
    if (rd_req) begin
      name_rd_q <= name_mem[in_data_i.read_index[cbp_pkg::NA_W-1:0]];
    end
  end

  // Passphrase store: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (pass_we) begin
      pass_mem[pc_q[cbp_pkg::PA_W-1:0]] <= b;
    end
    if (rd_req) begin
      pass_rd_q <= pass_mem[in_data_i.read_index[cbp_pkg::PA_W-1:0]];
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    out_data_o.status      = st_q;
    out_data_o.name_length = rn_q;
    out_data_o.pass_length = rp_q;
    if (!gate_q) begin
      out_data_o.read_data = 8'd0;
    end else if (sel_q == cbp_pkg::SEL_PASS) begin
      out_data_o.read_data = pass_rd_q;
    end else begin
      out_data_o.read_data = name_rd_q;
    end
  end

  // Assertions
  a_bc_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bc_q <= cbp_pkg::BC_W'(cbp_pkg::BLOB_LIMIT + 1))
    else $error("byte count beyond saturation");

  a_kept_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kn_q <= cbp_pkg::NC_W'(cbp_pkg::NAME_BYTES) &&
    kp_q <= cbp_pkg::PC_W'(cbp_pkg::PASS_BYTES))
    else $error("kept length exceeds store size");

  a_final_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && in_data_i.final_byte |=> phase_q == cbp_pkg::PH_HEADER && bc_q == '0 &&
    !adopted_q && out_valid_q)
    else $error("final byte did not rearm parser");

  a_read_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_req |=> out_valid_q && st_q == cbp_pkg::ST_FOUND)
    else $error("read request without response");

  a_hidden_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && st_q != cbp_pkg::ST_FOUND |-> rn_q == '0 && rp_q == '0)
    else $error("lengths reported for failed blob");

endmodule
`default_nettype wire

// ===== bench/credential_blob_parser_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// credential_blob_parser_core_tb - self-checking bench for the blob parser
// Streams directed and random credential blobs and interleaved byte reads
// through the parser. A request-level model of the parser predicts each status
// or read response, and every response is checked field by field.
// ----------------------------------------------------------------------------
module credential_blob_parser_core_tb;

  localparam int          CLK_HALF         = 6;
  localparam int          RESET_CYCLES     = 8;
  localparam int          SETTLE_CYCLES    = 4;
  localparam int          RANDOM_REQUESTS  = 400;
  localparam int          RANDOM_RESPONSES = 48;
  localparam logic [7:0]  NUL              = 8'h00;
  localparam logic [7:0]  MODE_PLAIN       = 8'h00;
  localparam logic [7:0]  MODE_STATIC      = 8'h01;

  // Receiver back-pressure patterns
  typedef enum int {ALWAYS_READY, COIN_FLIP, THREE_OF_FOUR, LONG_STALLS} stall_mode_e;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  cbp_pkg::req_t                in_data_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  cbp_pkg::rsp_t                out_data_o;
  logic                         cfg_we_i;
  logic                         cfg_idx_i;
  logic [cbp_pkg::CFG_W-1:0]    cfg_data_i;

  credential_blob_parser_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Parser model state: mirrors what the block holds between requests
  // --------------------------------------------------------------------------
  cbp_pkg::phase_e  p_phase;
  logic [10:0]      p_byte_cnt;
  logic [7:0]       p_entries;
  logic [5:0]       p_name_cnt;
  logic [6:0]       p_pass_cnt;
  logic [4:0]       p_skip_cnt;
  logic             p_adopted;
  logic             p_ready;
  logic [7:0]       p_name_mem [cbp_pkg::NAME_BYTES];
  logic [7:0]       p_pass_mem [cbp_pkg::PASS_BYTES];
  logic [5:0]       p_kept_name_len;
  logic [6:0]       p_kept_pass_len;
  logic [5:0]       p_name_room;
  logic [6:0]       p_pass_room;

  cbp_pkg::rsp_t    predicted_rsp_q [$];
  logic [7:0]       blob_buf [$];
  int               error_count;
  int               requests_sent;
  int               responses_seen;
  int               burst_left;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Rewind the counters for the next entry, or close the blob if none is left
  task automatic open_next_entry();
    p_name_cnt = '0;
    p_pass_cnt = '0;
    p_skip_cnt = '0;
    if (p_entries != 0) p_phase = cbp_pkg::PH_NAME;
    else p_phase = cbp_pkg::PH_DONE;
  endtask

  // Advance the parser model by one accepted request and queue its response, if any
  task automatic parse_blob_request(input cbp_pkg::req_t r);
    cbp_pkg::rsp_t rsp;
    int            nroom;
    int            proom;
    rsp = '0;
    if (r.opcode == cbp_pkg::OP_READ) begin
      // Reads see the kept credential only after a found status
      if (p_ready) begin
        rsp.name_length = p_kept_name_len;
        rsp.pass_length = p_kept_pass_len;
        if (r.read_which == cbp_pkg::SEL_NAME) begin
          if (r.read_index < p_kept_name_len && r.read_index < cbp_pkg::NAME_BYTES)
            rsp.read_data = p_name_mem[r.read_index[4:0]];
        end else if (r.read_index < p_kept_pass_len &&
                     r.read_index < cbp_pkg::PASS_BYTES) begin
          rsp.read_data = p_pass_mem[r.read_index];
        end
      end
      rsp.status = cbp_pkg::ST_FOUND;
      predicted_rsp_q.push_back(rsp);
    end else begin
      case (p_phase)
        cbp_pkg::PH_HEADER: begin
          // Byte 0 carries the entry count and drops the kept credential
          if (p_byte_cnt == 0) begin
            p_entries       = r.blob_byte;
            p_adopted       = 1'b0;
            p_ready         = 1'b0;
            p_kept_name_len = '0;
            p_kept_pass_len = '0;
          end else if (p_byte_cnt >= cbp_pkg::HDR_LAST) begin
            open_next_entry();
          end
        end
        cbp_pkg::PH_NAME: begin
          if (r.blob_byte == NUL) begin
            p_phase = cbp_pkg::PH_PASS;
          end else begin
            if (!p_adopted && p_name_cnt < cbp_pkg::NAME_BYTES)
              p_name_mem[p_name_cnt[4:0]] = r.blob_byte;
            if (p_name_cnt < cbp_pkg::NAME_BYTES + 1) p_name_cnt++;
          end
        end
        cbp_pkg::PH_PASS: begin
          if (r.blob_byte == NUL) begin
            p_phase    = cbp_pkg::PH_ADDR;
            p_skip_cnt = '0;
          end else begin
            if (!p_adopted && p_pass_cnt < cbp_pkg::PASS_BYTES)
              p_pass_mem[p_pass_cnt[5:0]] = r.blob_byte;
            if (p_pass_cnt < cbp_pkg::PASS_BYTES + 1) p_pass_cnt++;
          end
        end
        cbp_pkg::PH_ADDR: begin
          p_skip_cnt++;
          if (p_skip_cnt >= cbp_pkg::ADDR_LEN) p_phase = cbp_pkg::PH_MODE;
        end
        cbp_pkg::PH_MODE: begin
          // Rooms above the store size act as store size plus one
          nroom = (p_name_room > cbp_pkg::NAME_BYTES + 1) ? cbp_pkg::NAME_BYTES + 1
                                                          : int'(p_name_room);
          proom = (p_pass_room > cbp_pkg::PASS_BYTES + 1) ? cbp_pkg::PASS_BYTES + 1
                                                          : int'(p_pass_room);
          if (!p_adopted && p_name_cnt > 0 && p_name_cnt < nroom && p_pass_cnt < proom) begin
            p_adopted       = 1'b1;
            p_kept_name_len = p_name_cnt;
            p_kept_pass_len = p_pass_cnt;
          end
          if (p_entries != 0) p_entries--;
          if (r.blob_byte == MODE_STATIC) begin
            p_phase    = cbp_pkg::PH_SKIP;
            p_skip_cnt = '0;
          end else begin
            open_next_entry();
          end
        end
        cbp_pkg::PH_SKIP: begin
          p_skip_cnt++;
          if (p_skip_cnt >= cbp_pkg::STATIC_LEN) open_next_entry();
        end
        default: ;
      endcase
      if (p_byte_cnt < cbp_pkg::BLOB_LIMIT + 1) p_byte_cnt++;
      if (p_phase == cbp_pkg::PH_HEADER && p_byte_cnt >= cbp_pkg::HDR_LAST + 1 &&
          p_entries == 0)
        p_phase = cbp_pkg::PH_DONE;

      if (r.final_byte) begin
        if (p_byte_cnt < cbp_pkg::BLOB_MIN || p_byte_cnt > cbp_pkg::BLOB_LIMIT)
          rsp.status = cbp_pkg::ST_BAD_LEN;
        else if (p_adopted) rsp.status = cbp_pkg::ST_FOUND;
        else rsp.status = cbp_pkg::ST_NONE;
        p_ready = (rsp.status == cbp_pkg::ST_FOUND);
        if (!p_ready) begin
          p_kept_name_len = '0;
          p_kept_pass_len = '0;
        end
        p_adopted  = 1'b0;
        p_phase    = cbp_pkg::PH_HEADER;
        p_byte_cnt = '0;
        p_entries  = '0;
        p_name_cnt = '0;
        p_pass_cnt = '0;
        p_skip_cnt = '0;
        rsp.name_length = p_kept_name_len;
        rsp.pass_length = p_kept_pass_len;
        predicted_rsp_q.push_back(rsp);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Request side: bursts of back-to-back requests with random gaps between
  // --------------------------------------------------------------------------
  // Called and returns at a falling edge; holds valid and payload until taken.
  task automatic send_request(input cbp_pkg::req_t r);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(32, 160);
        gap        = 0;
      end else begin
        burst_left = $urandom_range(1, 12);
        gap        = $urandom_range(1, 6);
      end
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    parse_blob_request(r);
    requests_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_read(input logic which, input logic [5:0] index);
    cbp_pkg::req_t r;
    r.opcode     = cbp_pkg::OP_READ;
    r.blob_byte  = 8'($urandom_range(0, 255));
    r.final_byte = 1'($urandom_range(0, 1));
    r.read_which = which;
    r.read_index = index;
    send_request(r);
  endtask

  // Lean toward indexes around the kept length so the edge gets hit
  function automatic logic [5:0] pick_read_index(input logic which);
    int         span;
    logic [5:0] idx;
    span = (which == cbp_pkg::SEL_NAME) ? int'(p_kept_name_len) : int'(p_kept_pass_len);
    if (span > 62) span = 62;
    if ($urandom_range(0, 1) == 0) idx = 6'($urandom_range(0, span + 1));
    else idx = 6'($urandom_range(0, 63));
    return idx;
  endfunction

  task automatic read_back(input int n);
    logic which;
    repeat (n) begin
      which = 1'($urandom_range(0, 1));
      send_read(which, pick_read_index(which));
    end
  endtask

  // Drop valid and hold until every queued response has been checked
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (predicted_rsp_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_room(input logic idx, input logic [cbp_pkg::CFG_W-1:0] value);
    wait_for_drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == cbp_pkg::CFG_NAME_ROOM) p_name_room = value[5:0];
    else p_pass_room = value;
  endtask

  // --------------------------------------------------------------------------
  // Blob assembly
  // --------------------------------------------------------------------------
  task automatic start_blob(input logic [7:0] count);
    blob_buf.delete();
    blob_buf.push_back(count);
    blob_buf.push_back(8'($urandom_range(0, 255)));
    blob_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_entry(input int name_len, input int pass_len, input logic [7:0] mode);
    repeat (name_len) blob_buf.push_back(8'($urandom_range(1, 255)));
    blob_buf.push_back(NUL);
    repeat (pass_len) blob_buf.push_back(8'($urandom_range(1, 255)));
    blob_buf.push_back(NUL);
    repeat (cbp_pkg::ADDR_LEN) blob_buf.push_back(8'($urandom_range(0, 255)));
    blob_buf.push_back(mode);
    if (mode == MODE_STATIC)
      repeat (cbp_pkg::STATIC_LEN) blob_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic pad_blob(input int total);
    while (blob_buf.size() < total) blob_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  // Push the assembled blob, marking the last byte final; a nonzero read_odds
  // slips a read in before a byte about once in read_odds bytes
  task automatic send_blob(input int read_odds);
    cbp_pkg::req_t r;
    int            last;
    logic          which;
    last = blob_buf.size() - 1;
    for (int i = 0; i <= last; i++) begin
      if (read_odds != 0 && $urandom_range(0, read_odds - 1) == 0) begin
        which = 1'($urandom_range(0, 1));
        send_read(which, pick_read_index(which));
      end
      r.opcode     = cbp_pkg::OP_PUSH;
      r.blob_byte  = blob_buf[i];
      r.final_byte = (i == last);
      r.read_which = 1'($urandom_range(0, 1));
      r.read_index = 6'($urandom_range(0, 63));
      send_request(r);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Nothing is kept after reset, so reads return zeros
  task automatic test_idle_reads();
    send_read(cbp_pkg::SEL_NAME, 6'd0);
    send_read(cbp_pkg::SEL_PASS, 6'd63);
  endtask

  task automatic test_found_entry();
    start_blob(8'd1);
    add_entry(2, 3, MODE_PLAIN);
    send_blob(0);
    for (int i = 0; i < 4; i++) send_read(cbp_pkg::SEL_NAME, 6'(i));
    for (int i = 0; i < 5; i++) send_read(cbp_pkg::SEL_PASS, 6'(i));
    send_read(cbp_pkg::SEL_NAME, 6'd63);
  endtask

  // Empty name is skipped, static block is skipped, empty passphrase is fine
  task automatic test_skip_and_empty_name();
    start_blob(8'd3);
    add_entry(0, 4, MODE_STATIC);
    add_entry(5, 0, 8'hFF);
    add_entry(3, 3, MODE_PLAIN);
    send_blob(0);
    read_back(4);
  endtask

  task automatic test_truncated_and_extra();
    // Second entry loses its mode byte, so nothing is kept
    start_blob(8'd2);
    add_entry(0, 1, MODE_PLAIN);
    add_entry(4, 4, MODE_PLAIN);
    void'(blob_buf.pop_back());
    send_blob(0);
    // Trailing bytes past the last counted entry are ignored
    start_blob(8'd1);
    add_entry(2, 2, MODE_PLAIN);
    pad_blob(blob_buf.size() + 10);
    send_blob(0);
    // No entries at all
    start_blob(8'd0);
    pad_blob(cbp_pkg::BLOB_MIN + 1);
    send_blob(0);
    // Header only, then a single byte: both too short
    start_blob(8'd5);
    send_blob(0);
    blob_buf.delete();
    blob_buf.push_back(8'hFF);
    send_blob(0);
    read_back(2);
  endtask

  task automatic test_room_limits();
    // Room of zero accepts nothing
    write_room(cbp_pkg::CFG_NAME_ROOM, 7'd0);
    start_blob(8'd1);
    add_entry(1, 1, MODE_PLAIN);
    send_blob(0);
    // Top bit drops off the name room; 63 then clamps to store size plus one
    write_room(cbp_pkg::CFG_NAME_ROOM, 7'h7F);
    start_blob(8'd2);
    add_entry(cbp_pkg::NAME_BYTES + 1, 1, MODE_PLAIN);
    add_entry(cbp_pkg::NAME_BYTES, 2, MODE_PLAIN);
    send_blob(0);
    send_read(cbp_pkg::SEL_NAME, 6'(cbp_pkg::NAME_BYTES - 1));
    send_read(cbp_pkg::SEL_NAME, 6'(cbp_pkg::NAME_BYTES));
    // Name length must be strictly below the room
    write_room(cbp_pkg::CFG_NAME_ROOM, 7'd3);
    start_blob(8'd2);
    add_entry(3, 1, MODE_PLAIN);
    add_entry(2, 1, MODE_PLAIN);
    send_blob(0);
    write_room(cbp_pkg::CFG_PASS_ROOM, 7'd0);
    start_blob(8'd1);
    add_entry(1, 0, MODE_PLAIN);
    send_blob(0);
    write_room(cbp_pkg::CFG_PASS_ROOM, 7'd1);
    start_blob(8'd2);
    add_entry(1, 1, MODE_PLAIN);
    add_entry(1, 0, MODE_PLAIN);
    send_blob(0);
    // Full-size passphrase kept, one byte more rejected
    write_room(cbp_pkg::CFG_PASS_ROOM, 7'h7F);
    write_room(cbp_pkg::CFG_NAME_ROOM, 7'(cbp_pkg::NAME_BYTES + 1));
    start_blob(8'd2);
    add_entry(2, cbp_pkg::PASS_BYTES + 1, MODE_PLAIN);
    add_entry(1, cbp_pkg::PASS_BYTES, MODE_STATIC);
    send_blob(0);
    send_read(cbp_pkg::SEL_PASS, 6'(cbp_pkg::PASS_BYTES - 1));
    write_room(cbp_pkg::CFG_PASS_ROOM, 7'(cbp_pkg::PASS_BYTES + 1));
  endtask

  // Kept lengths read as zero from the first byte of a new blob on
  task automatic test_reads_during_blob();
    start_blob(8'd1);
    add_entry(6, 6, MODE_PLAIN);
    send_blob(0);
    start_blob(8'd1);
    add_entry(3, 3, MODE_PLAIN);
    send_blob(2);
    read_back(3);
  endtask

  task automatic test_length_limits();
    start_blob(8'd1);
    add_entry(4, 4, MODE_PLAIN);
    pad_blob(cbp_pkg::BLOB_LIMIT);
    send_blob(0);
    read_back(2);
    // One byte too many: bad length even with an entry kept
    start_blob(8'd1);
    add_entry(4, 4, MODE_PLAIN);
    pad_blob(cbp_pkg::BLOB_LIMIT + 1);
    send_blob(0);
    read_back(2);
    start_blob(8'd0);
    pad_blob(cbp_pkg::BLOB_MIN);
    send_blob(0);
  endtask

  function automatic logic [cbp_pkg::CFG_W-1:0] pick_room(input int dflt);
    logic [cbp_pkg::CFG_W-1:0] v;
    case ($urandom_range(0, 5))
      0:       v = '0;
      1:       v = '1;
      2:       v = cbp_pkg::CFG_W'(dflt);
      3, 4:    v = cbp_pkg::CFG_W'($urandom_range(1, 12));
      default: v = cbp_pkg::CFG_W'($urandom_range(0, 127));
    endcase
    return v;
  endfunction

  task automatic add_random_entry();
    int          name_len;
    int          pass_len;
    logic [7:0]  mode;
    int          pick;
    name_len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
    pass_len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 70) : $urandom_range(0, 10);
    pick = $urandom_range(0, 9);
    if (pick < 5) mode = MODE_STATIC;
    else if (pick < 8) mode = MODE_PLAIN;
    else mode = 8'($urandom_range(0, 255));
    add_entry(name_len, pass_len, mode);
  endtask

  // Mostly well-formed blobs with random content, plus cut, padded and noise blobs and room writes
  task automatic test_random_traffic();
    int sent_goal;
    int resp_goal;
    int kind;
    int n_entries;
    sent_goal = requests_sent + RANDOM_REQUESTS;
    resp_goal = responses_seen + RANDOM_RESPONSES;
    while (requests_sent < sent_goal || responses_seen < resp_goal) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        if ($urandom_range(0, 1))
          write_room(cbp_pkg::CFG_NAME_ROOM, pick_room(cbp_pkg::NAME_BYTES + 1));
        if ($urandom_range(0, 1))
          write_room(cbp_pkg::CFG_PASS_ROOM, pick_room(cbp_pkg::PASS_BYTES + 1));
      end else begin
        if (kind <= 2) begin
          blob_buf.delete();
          pad_blob($urandom_range(1, 12));
        end else begin
          n_entries = $urandom_range(1, 4);
          start_blob(8'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : n_entries));
          repeat (n_entries) add_random_entry();
          if (kind <= 4) begin
            n_entries = $urandom_range(1, blob_buf.size());
            while (blob_buf.size() > n_entries) void'(blob_buf.pop_back());
          end else if (kind <= 6) begin
            pad_blob(blob_buf.size() + $urandom_range(1, 10));
          end
        end
        send_blob(16);
        read_back($urandom_range(0, 5));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Response side: stall on one of four patterns, picked anew at random
  // --------------------------------------------------------------------------
  initial begin : rsp_stall_gen
    stall_mode_e mode;
    int          mode_left;
    int          tick;
    out_ready_i = 1'b0;
    mode        = ALWAYS_READY;
    mode_left   = 0;
    tick        = 0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        mode      = stall_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      tick++;
      case (mode)
        ALWAYS_READY:  out_ready_i <= 1'b1;
        COIN_FLIP:     out_ready_i <= 1'($urandom_range(0, 1));
        THREE_OF_FOUR: out_ready_i <= (tick % 4 != 3);
        default:       out_ready_i <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Compare every accepted response against the oldest prediction
  always @(posedge clk_i) begin : rsp_check
    cbp_pkg::rsp_t want;
    if (out_valid_o && out_ready_i) begin
      if (predicted_rsp_q.size() == 0) begin
        $error("response with none pending: %h", out_data_o);
        error_count++;
      end else begin
        want = predicted_rsp_q.pop_front();
        responses_seen++;
        if (out_data_o.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_data_o.status);
          error_count++;
        end
        if (out_data_o.name_length !== want.name_length) begin
          $error("name_length: expected %0d, actual %0d",
                 want.name_length, out_data_o.name_length);
          error_count++;
        end
        if (out_data_o.pass_length !== want.pass_length) begin
          $error("pass_length: expected %0d, actual %0d",
                 want.pass_length, out_data_o.pass_length);
          error_count++;
        end
        if (out_data_o.read_data !== want.read_data) begin
          $error("read_data: expected %0d, actual %0d", want.read_data, out_data_o.read_data);
          error_count++;
        end
      end
    end
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("** credential_blob_parser_core: FAILED **");
    $finish;
  end

  initial begin
    in_valid_i      = 1'b0;
    in_data_i       = '0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = cbp_pkg::CFG_NAME_ROOM;
    cfg_data_i      = '0;
    rst_ni          = 1'b0;
    error_count     = 0;
    requests_sent   = 0;
    responses_seen  = 0;
    burst_left      = 0;
    // Model comes out of reset with full rooms and nothing kept
    p_phase         = cbp_pkg::PH_HEADER;
    p_byte_cnt      = '0;
    p_entries       = '0;
    p_name_cnt      = '0;
    p_pass_cnt      = '0;
    p_skip_cnt      = '0;
    p_adopted       = 1'b0;
    p_ready         = 1'b0;
    p_kept_name_len = '0;
    p_kept_pass_len = '0;
    p_name_room     = 6'(cbp_pkg::NAME_BYTES + 1);
    p_pass_room     = 7'(cbp_pkg::PASS_BYTES + 1);

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_idle_reads();
    test_found_entry();
    test_skip_and_empty_name();
    test_truncated_and_extra();
    test_room_limits();
    test_reads_during_blob();
    test_length_limits();
    test_random_traffic();

    wait_for_drain();
    if (error_count == 0 && predicted_rsp_q.size() == 0) begin
      $display("** credential_blob_parser_core: PASSED **");
    end else begin
      $display("** credential_blob_parser_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== credential_blob_parser_core.f =====
src/cbp_pkg.sv
src/credential_blob_parser_core.sv
bench/credential_blob_parser_core_tb.sv
